// ===== src/wpp_pkg.sv =====
`timescale 1ns / 1ps

package wpp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM        = 16'd1;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'd65534;
	localparam logic [15:0] SAMPLE_BITS    = 16'd16;
	localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;

	localparam int MIN_FILE_BYTES = 44;
	localparam int COUNT_W        = $clog2(MIN_FILE_BYTES + 1);

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOT_RIFF = 3'd1;
	localparam logic [2:0] ST_BAD_FMT  = 3'd2;
	localparam logic [2:0] ST_MISSING  = 3'd3;
	localparam logic [2:0] ST_NOT_PCM  = 3'd4;
	localparam logic [2:0] ST_MISMATCH = 3'd5;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int  ADDR_W       = 3;
	localparam logic REG_RATE     = 1'b0;
	localparam logic REG_CHANNELS = 1'b1;

	localparam logic [31:0] RATE_RESET     = 32'd16000;
	localparam logic [15:0] CHANNELS_RESET = 16'd1;

	typedef struct packed {
		logic [31:0] rate;
		logic [15:0] channels;
	} cfg_t;

	typedef struct packed {
		logic               has_sample;
		logic signed [15:0] sample;
		logic               has_status;
		logic [2:0]         status;
	} rec_t;

endpackage

// ===== src/wpp_byte_if.sv =====
`timescale 1ns / 1ps

interface wpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       end_of_file;

	modport source (output valid, output file_byte, output end_of_file, input ready);
	modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

// ===== src/wpp_res_if.sv =====
`timescale 1ns / 1ps

interface wpp_res_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] sample;
	logic [2:0]         status;
	logic               final_res;

	modport source (output valid, output kind, output sample, output status,
		output final_res, input ready);
	modport sink (input valid, input kind, input sample, input status,
		input final_res, output ready);
endinterface

// ===== src/wpp_regs.sv =====
`timescale 1ns / 1ps

module wpp_regs
	import wpp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate     <= RATE_RESET;
			cfg_q.channels <= CHANNELS_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_RATE:     cfg_q.rate     <= pwdata;
				REG_CHANNELS: cfg_q.channels <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RATE:     prdata = cfg_q.rate;
			REG_CHANNELS: prdata = {16'd0, cfg_q.channels};
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== src/wpp_front.sv =====
`timescale 1ns / 1ps

module wpp_front
	import wpp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	wpp_byte_if.sink byte_in,
	input  logic   queue_full,
	output logic   push,
	output rec_t   push_rec
);

	typedef enum logic [7:0] {
		PH_RIFF  = 8'b0000_0001,
		PH_HDR   = 8'b0000_0010,
		PH_FMT   = 8'b0000_0100,
		PH_SKIP  = 8'b0000_1000,
		PH_PAD   = 8'b0001_0000,
		PH_DATA  = 8'b0010_0000,
		PH_DRAIN = 8'b0100_0000,
		PH_ERR   = 8'b1000_0000
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [COUNT_W-1:0]   count_q, count_n;
	logic [31:0]          pos_q, pos_n, pos_inc;
	logic                 fmt_seen_q, fmt_seen_n;
	logic [2:0]           err_q, err_n;
	logic [31:0]          tag_q, tag_n, tag_sh;
	logic [31:0]          size_q, size_n;
	logic [15:0]          format_q, format_n;
	logic [15:0]          chans_q, chans_n;
	logic [31:0]          rate_q, rate_n;
	logic [15:0]          bits_q, bits_n;
	logic [7:0]           hold_q, hold_n;
	logic                 to_end_q, to_end_n;
	logic                 accept;
	logic [7:0]           b;
	logic [4:0]           shamt;
	logic                 emit;
	logic [2:0]           st;

	assign byte_in.ready = !queue_full;
	assign accept        = byte_in.valid && byte_in.ready;
	assign b             = byte_in.file_byte;
	assign shamt         = {pos_q[1:0], 3'b000};
	assign tag_sh        = {tag_q[23:0], b};
	assign pos_inc       = pos_q + 32'd1;

	always_comb begin
		phase_n    = phase_q;
		count_n    = (count_q == COUNT_W'(MIN_FILE_BYTES)) ? count_q : count_q + 1'b1;
		pos_n      = pos_q;
		fmt_seen_n = fmt_seen_q;
		err_n      = err_q;
		tag_n      = tag_q;
		size_n     = size_q;
		format_n   = format_q;
		chans_n    = chans_q;
		rate_n     = rate_q;
		bits_n     = bits_q;
		hold_n     = hold_q;
		to_end_n   = to_end_q;
		emit       = 1'b0;
		st         = ST_OK;

		unique case (phase_q) inside
			PH_RIFF: begin
				tag_n = tag_sh;
				if (count_q == COUNT_W'(3) && tag_sh != TAG_RIFF) begin
					err_n   = ST_NOT_RIFF;
					phase_n = PH_ERR;
				end else if (count_q == COUNT_W'(11)) begin
					if (tag_sh != TAG_WAVE) begin
						err_n   = ST_NOT_RIFF;
						phase_n = PH_ERR;
					end else begin
						phase_n = PH_HDR;
						pos_n   = '0;
					end
				end
			end
			PH_HDR: begin
				if (pos_q < 32'd4) begin
					tag_n = tag_sh;
					if (pos_q == 32'd0) begin
						size_n = '0;
					end
				end else begin
					size_n = size_q | (32'(b) << shamt);
				end
				pos_n = pos_inc;
				if (pos_inc >= 32'd8) begin
					pos_n = '0;
					if (tag_n == TAG_FMT) begin
						if (size_n < FMT_MIN_SIZE) begin
							err_n   = ST_BAD_FMT;
							phase_n = PH_ERR;
						end else begin
							phase_n = PH_FMT;
						end
					end else if (tag_n == TAG_DATA) begin
						if (!fmt_seen_q) begin
							err_n   = ST_MISSING;
							phase_n = PH_ERR;
						end else if (format_q != FMT_PCM && format_q != FMT_EXTENSIBLE) begin
							err_n   = ST_NOT_PCM;
							phase_n = PH_ERR;
						end else if (chans_q != cfg.channels || rate_q != cfg.rate ||
							bits_q != SAMPLE_BITS) begin
							err_n   = ST_MISMATCH;
							phase_n = PH_ERR;
						end else begin
							to_end_n = (size_n == 32'd0);
							phase_n  = PH_DATA;
						end
					end else if (size_n == 32'd0) begin
						phase_n = PH_HDR;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_FMT: begin
				case (pos_q) inside
					32'd0: begin
						format_n = {8'd0, b};
						chans_n  = '0;
						rate_n   = '0;
						bits_n   = '0;
					end
					32'd1: format_n = {b, format_q[7:0]};
					32'd2: chans_n = {8'd0, b};
					32'd3: chans_n = {b, chans_q[7:0]};
					[32'd4:32'd7]: rate_n = rate_q | (32'(b) << shamt);
					32'd14: bits_n = {8'd0, b};
					32'd15: begin
						bits_n     = {b, bits_q[7:0]};
						fmt_seen_n = 1'b1;
					end
					default: ;
				endcase
				pos_n = pos_inc;
				if (pos_inc == size_q) begin
					pos_n   = '0;
					phase_n = size_q[0] ? PH_PAD : PH_HDR;
				end
			end
			PH_SKIP: begin
				pos_n = pos_inc;
				if (pos_inc == size_q) begin
					pos_n   = '0;
					phase_n = size_q[0] ? PH_PAD : PH_HDR;
				end
			end
			PH_PAD: begin
				phase_n = PH_HDR;
				pos_n   = '0;
			end
			PH_DATA: begin
				if (!pos_q[0]) begin
					hold_n = b;
				end else begin
					emit = 1'b1;
				end
				pos_n = pos_inc;
				if (!to_end_q && pos_inc == size_q) begin
					phase_n = PH_DRAIN;
				end
			end
			PH_DRAIN, PH_ERR: ;
			default: ;
		endcase

		if (byte_in.end_of_file) begin
			if (count_n < COUNT_W'(MIN_FILE_BYTES)) begin
				st = ST_NOT_RIFF;
			end else if (phase_n == PH_ERR) begin
				st = err_n;
			end else if (phase_n == PH_DATA || phase_n == PH_DRAIN) begin
				st = ST_OK;
			end else if (phase_n == PH_FMT) begin
				st = ST_BAD_FMT;
			end else begin
				st = ST_MISSING;
			end
			phase_n    = PH_RIFF;
			count_n    = '0;
			pos_n      = '0;
			fmt_seen_n = 1'b0;
			err_n      = ST_OK;
			to_end_n   = 1'b0;
		end
	end

	assign push                = accept && (emit || byte_in.end_of_file);
	assign push_rec.has_sample = emit;
	assign push_rec.sample     = $signed({b, hold_q});
	assign push_rec.has_status = byte_in.end_of_file;
	assign push_rec.status     = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF;
			count_q    <= '0;
			pos_q      <= '0;
			fmt_seen_q <= 1'b0;
			err_q      <= ST_OK;
			to_end_q   <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			count_q    <= count_n;
			pos_q      <= pos_n;
			fmt_seen_q <= fmt_seen_n;
			err_q      <= err_n;
			to_end_q   <= to_end_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q    <= tag_n;
			size_q   <= size_n;
			format_q <= format_n;
			chans_q  <= chans_n;
			rate_q   <= rate_n;
			bits_q   <= bits_n;
			hold_q   <= hold_n;
		end
	end

endmodule

// ===== src/wpp_queue.sv =====
`timescale 1ns / 1ps

module wpp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/wpp_back.sv =====
`timescale 1ns / 1ps

module wpp_back
	import wpp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic queue_empty,
	input  rec_t pop_rec,
	output logic pop,
	wpp_res_if.source result_out
);

	logic               valid_q;
	logic               kind_q;
	logic signed [15:0] sample_q;
	logic [2:0]         status_q;
	logic               pend_q;
	logic [2:0]         pend_status_q;
	logic               can_load;

	assign can_load = !valid_q || result_out.ready;
	assign pop      = can_load && !pend_q && !queue_empty;

	assign result_out.valid     = valid_q;
	assign result_out.kind      = kind_q;
	assign result_out.sample    = sample_q;
	assign result_out.status    = status_q;
	assign result_out.final_res = (kind_q == KIND_STATUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (can_load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!queue_empty) begin
				valid_q <= 1'b1;
				pend_q  <= pop_rec.has_sample && pop_rec.has_status;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (pend_q) begin
				kind_q   <= KIND_STATUS;
				sample_q <= '0;
				status_q <= pend_status_q;
			end else if (!queue_empty) begin
				pend_status_q <= pop_rec.status;
				if (pop_rec.has_sample) begin
					kind_q   <= KIND_SAMPLE;
					sample_q <= pop_rec.sample;
					status_q <= ST_OK;
				end else begin
					kind_q   <= KIND_STATUS;
					sample_q <= '0;
					status_q <= pop_rec.status;
				end
			end
		end
	end

endmodule

// ===== src/wav_pcm16_stream_parser.sv =====
`timescale 1ns / 1ps

// Byte-serial parser for RIFF/WAVE files carrying 16-bit PCM of the configured channel count.
// One file byte is taken per clock as long as the result queue has room; the header walk, fmt
// capture and format checks are all per-byte field updates, so the input side sustains one
// transfer per cycle. Each pair of data bytes yields one signed Q1.15 sample transfer, and the
// byte marked end_of_file yields a final status transfer as well. Results pass through a short
// queue and an output register, so a stalled output holds up input only once the queue has
// filled. Write the expected rate and channel count over the APB port while no file is in
// progress (not enforced); parsing restarts from the RIFF tag after each end_of_file byte.

module wav_pcm16_stream_parser
	import wpp_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	wpp_byte_if.sink          byte_in,
	wpp_res_if.source         result_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t cfg;
	logic push, pop, full, empty;
	rec_t push_rec, pop_rec;

	wpp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_in    (byte_in),
		.queue_full (full),
		.push       (push),
		.push_rec   (push_rec)
	);

	wpp_queue #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_rec),
		.empty     (empty)
	);

	wpp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (empty),
		.pop_rec     (pop_rec),
		.pop         (pop),
		.result_out  (result_out)
	);

endmodule
